// ===== rtl/smt_pkg.sv =====
package smt_pkg;

  // last-sign codes of an axis error
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_EN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_EN   = 2'd3;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // per-transaction control into each axis
  typedef struct packed {
    logic en;     // commit the update this cycle
    logic start;  // clear and seed the peak error
    logic valid;  // target seen: full sample update
    logic seen;   // previous pulses exist for the step measurement
  } axis_ctrl_t;

  // metrics of one axis after the update
  typedef struct packed {
    logic [15:0] settle;
    logic [15:0] crossings;
    logic [15:0] peak_step;
    logic [12:0] peak_err;  // up to 2048, so one bit over the port width
  } axis_stats_t;

endpackage

// ===== rtl/step_response_metrics_tracker.sv =====
// Step response metrics tracker.
// Input channel (in_*): one tracking sample per transaction, taken when
// in_valid is high and in_stall is low. A start sample clears all metrics
// and seeds the peak errors; a lost-target sample only counts and breaks
// the stable runs.
// Result channel (out_*): exactly one result per sample, handed over when
// out_valid is high and out_stall is low.
// Configuration channel (cfg_*): index/data writes, always ready; write
// only while no sample is in flight.
// Path: each sample passes the input register, then the single-pass
// update into the result register, which raises out_valid.
// Throughput: one sample per cycle while out_stall allows; the axis update
// is one short compare and count pass, so the state feedback closes within it.
// When the receiver stalls, the result register holds and the input
// register still takes one further sample before in_stall rises.
// Reset (rst_n low, synchronous) clears all metrics, empties both
// registers and loads the configuration defaults: deadband 4, stable run
// length 5, both axes enabled.
module step_response_metrics_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic                          in_target_valid,
  input  logic signed [11:0]            in_yaw_error,
  input  logic signed [11:0]            in_pitch_error,
  input  logic signed [15:0]            in_yaw_pulses,
  input  logic signed [15:0]            in_pitch_pulses,
  input  logic [15:0]                   in_elapsed_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_settled,
  output logic [15:0]                   out_yaw_settle_ms,
  output logic [15:0]                   out_pitch_settle_ms,
  output logic [15:0]                   out_yaw_crossings,
  output logic [15:0]                   out_pitch_crossings,
  output logic [15:0]                   out_yaw_peak_step,
  output logic [15:0]                   out_pitch_peak_step,
  output logic [11:0]                   out_yaw_peak_error,
  output logic [11:0]                   out_pitch_peak_error,
  output logic [15:0]                   out_valid_count,
  output logic [15:0]                   out_lost_count,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import smt_pkg::*;

  // configuration registers
  logic [7:0]  deadband_r;
  logic [15:0] stable_len_r;
  logic        yaw_en_r;
  logic        pitch_en_r;

  // input register
  logic               in_q_valid_r;
  logic               in_q_start_r;
  logic               in_q_tv_r;
  logic signed [11:0] in_q_yaw_err_r;
  logic signed [11:0] in_q_pitch_err_r;
  logic signed [15:0] in_q_yaw_pul_r;
  logic signed [15:0] in_q_pitch_pul_r;
  logic [15:0]        in_q_elapsed_r;

  // shared sample state
  logic        seen_r, seen_nxt;
  logic [15:0] valid_total_r, valid_total_nxt;
  logic [15:0] lost_total_r, lost_total_nxt;

  // result register
  logic        out_valid_r;
  logic        out_settled_r;
  axis_stats_t out_yaw_r, out_pitch_r;
  logic [15:0] out_valid_cnt_r, out_lost_cnt_r;

  logic          in_accept;
  logic          advance;
  logic          settled_nxt;
  axis_ctrl_t    axis_ctrl;
  axis_stats_t   yaw_nxt, pitch_nxt;

  // advance the held sample when the result slot is free or being emptied
  assign advance   = in_q_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_q_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= 8'd4;
      stable_len_r <= 16'd5;
      yaw_en_r     <= 1'b1;
      pitch_en_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADBAND:   deadband_r   <= cfg_data[7:0];
        CFG_STABLE_LEN: stable_len_r <= cfg_data;
        CFG_YAW_EN:     yaw_en_r     <= cfg_data[0];
        CFG_PITCH_EN:   pitch_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: valid bit under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_q_valid_r <= 1'b1;
    end else if (advance) begin
      in_q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_start_r     <= in_start_req;
      in_q_tv_r        <= in_target_valid;
      in_q_yaw_err_r   <= in_yaw_error;
      in_q_pitch_err_r <= in_pitch_error;
      in_q_yaw_pul_r   <= in_yaw_pulses;
      in_q_pitch_pul_r <= in_pitch_pulses;
      in_q_elapsed_r   <= in_elapsed_ms;
    end
  end

  assign axis_ctrl.en    = advance;
  assign axis_ctrl.start = in_q_start_r;
  assign axis_ctrl.valid = in_q_tv_r;
  assign axis_ctrl.seen  = seen_r;

  smt_axis u_yaw (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (axis_ctrl),
    .deadband    (deadband_r),
    .stable_len  (stable_len_r),
    .err         (in_q_yaw_err_r),
    .pulses      (in_q_yaw_pul_r),
    .elapsed     (in_q_elapsed_r),
    .metrics_nxt (yaw_nxt)
  );

  smt_axis u_pitch (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (axis_ctrl),
    .deadband    (deadband_r),
    .stable_len  (stable_len_r),
    .err         (in_q_pitch_err_r),
    .pulses      (in_q_pitch_pul_r),
    .elapsed     (in_q_elapsed_r),
    .metrics_nxt (pitch_nxt)
  );

  // sample counters and the seen flag; start clears, counters saturate
  always_comb begin
    seen_nxt        = seen_r;
    valid_total_nxt = valid_total_r;
    lost_total_nxt  = lost_total_r;
    priority if (in_q_start_r) begin
      seen_nxt        = 1'b0;
      valid_total_nxt = '0;
      lost_total_nxt  = '0;
    end else if (in_q_tv_r) begin
      seen_nxt = 1'b1;
      if (valid_total_r != SAT16) begin
        valid_total_nxt = valid_total_r + 16'd1;
      end
    end else begin
      if (lost_total_r != SAT16) begin
        lost_total_nxt = lost_total_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= 1'b0;
      valid_total_r <= '0;
      lost_total_r  <= '0;
    end else if (advance) begin
      seen_r        <= seen_nxt;
      valid_total_r <= valid_total_nxt;
      lost_total_r  <= lost_total_nxt;
    end
  end

  // a disabled axis never holds the decision back
  assign settled_nxt = (!yaw_en_r || (yaw_nxt.settle != '0)) &&
                       (!pitch_en_r || (pitch_nxt.settle != '0));

  // result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_settled_r   <= settled_nxt;
      out_yaw_r       <= yaw_nxt;
      out_pitch_r     <= pitch_nxt;
      out_valid_cnt_r <= valid_total_nxt;
      out_lost_cnt_r  <= lost_total_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_settled          = out_settled_r;
  assign out_yaw_settle_ms    = out_yaw_r.settle;
  assign out_pitch_settle_ms  = out_pitch_r.settle;
  assign out_yaw_crossings    = out_yaw_r.crossings;
  assign out_pitch_crossings  = out_pitch_r.crossings;
  assign out_yaw_peak_step    = out_yaw_r.peak_step;
  assign out_pitch_peak_step  = out_pitch_r.peak_step;
  assign out_yaw_peak_error   = out_yaw_r.peak_err[11:0];
  assign out_pitch_peak_error = out_pitch_r.peak_err[11:0];
  assign out_valid_count      = out_valid_cnt_r;
  assign out_lost_count       = out_lost_cnt_r;

  // the input side only stalls while a sample is held
  a_stall_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_q_valid_r)
    else $error("input stalled with an empty input register");

  // a start transaction reports cleared sample counts
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_q_start_r |=> out_valid_count == '0 && out_lost_count == '0)
    else $error("start did not clear sample counts");

  // a lost sample never moves the valid count
  a_lost_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_q_start_r && !in_q_tv_r |=> valid_total_r == $past(valid_total_r))
    else $error("lost sample changed the valid count");

endmodule

// ===== rtl/smt_axis.sv =====
module smt_axis (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smt_pkg::axis_ctrl_t   ctrl,
  input  logic [7:0]            deadband,
  input  logic [15:0]           stable_len,
  input  logic signed [11:0]    err,
  input  logic signed [15:0]    pulses,
  input  logic [15:0]           elapsed,
  output smt_pkg::axis_stats_t  metrics_nxt
);
  import smt_pkg::*;

  logic [1:0]  last_sign_r, last_sign_nxt;
  logic [15:0] crossings_r, crossings_nxt;
  logic [15:0] prev_pulses_r, prev_pulses_nxt;
  logic [15:0] step_peak_r, step_peak_nxt;
  logic [15:0] stable_run_r, stable_run_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic [12:0] err_peak_r, err_peak_nxt;

  logic [12:0] err_ext;
  logic [12:0] err_mag;
  logic        in_band;
  logic [1:0]  sign;
  logic [16:0] diff;
  logic [16:0] diff_neg;
  logic [15:0] step;
  logic [15:0] run_inc;

  assign err_ext  = {err[11], err};
  assign err_mag  = err_ext[12] ? (~err_ext + 13'd1) : err_ext;
  assign in_band  = (err_mag <= {5'd0, deadband});
  assign sign     = in_band ? SIGN_NONE : (err[11] ? SIGN_NEG : SIGN_POS);
  assign diff     = {pulses[15], pulses} - {prev_pulses_r[15], prev_pulses_r};
  assign diff_neg = ~diff + 17'd1;
  assign step     = diff[16] ? diff_neg[15:0] : diff[15:0];
  assign run_inc  = stable_run_r + 16'd1;

  always_comb begin
    last_sign_nxt   = last_sign_r;
    crossings_nxt   = crossings_r;
    prev_pulses_nxt = prev_pulses_r;
    step_peak_nxt   = step_peak_r;
    stable_run_nxt  = stable_run_r;
    settle_nxt      = settle_r;
    err_peak_nxt    = err_peak_r;
    priority if (ctrl.start) begin
      last_sign_nxt   = SIGN_NONE;
      crossings_nxt   = '0;
      prev_pulses_nxt = '0;
      step_peak_nxt   = '0;
      stable_run_nxt  = '0;
      settle_nxt      = '0;
      err_peak_nxt    = err_mag;
    end else if (ctrl.valid) begin
      if (sign != SIGN_NONE) begin
        if ((last_sign_r != SIGN_NONE) && (last_sign_r != sign) && (crossings_r != SAT16)) begin
          crossings_nxt = crossings_r + 16'd1;
        end
        last_sign_nxt = sign;
      end
      if (ctrl.seen && (step > step_peak_r)) begin
        step_peak_nxt = step;
      end
      prev_pulses_nxt = pulses;
      if (err_mag > err_peak_r) begin
        err_peak_nxt = err_mag;
      end
      if (in_band) begin
        if (stable_run_r != SAT16) begin
          stable_run_nxt = run_inc;
          if (run_inc == stable_len) begin
            settle_nxt = elapsed;
          end
        end
      end else begin
        stable_run_nxt = '0;
        settle_nxt     = '0;
      end
    end else begin
      stable_run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sign_r   <= SIGN_NONE;
      crossings_r   <= '0;
      prev_pulses_r <= '0;
      step_peak_r   <= '0;
      stable_run_r  <= '0;
      settle_r      <= '0;
      err_peak_r    <= '0;
    end else if (ctrl.en) begin
      last_sign_r   <= last_sign_nxt;
      crossings_r   <= crossings_nxt;
      prev_pulses_r <= prev_pulses_nxt;
      step_peak_r   <= step_peak_nxt;
      stable_run_r  <= stable_run_nxt;
      settle_r      <= settle_nxt;
      err_peak_r    <= err_peak_nxt;
    end
  end

  assign metrics_nxt.settle    = settle_nxt;
  assign metrics_nxt.crossings = crossings_nxt;
  assign metrics_nxt.peak_step = step_peak_nxt;
  assign metrics_nxt.peak_err  = err_peak_nxt;

  // only a start may make a crossing count go down
  a_cross_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.en && !ctrl.start |=> crossings_r >= $past(crossings_r))
    else $error("crossing count decreased without start");

  // a lost sample leaves the latched settle time alone
  a_lost_keeps_settle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.en && !ctrl.start && !ctrl.valid |=> settle_r == $past(settle_r) && stable_run_r == '0)
    else $error("lost sample disturbed settle time or stable run");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import smt_pkg::*;

  // One tracking sample as it crosses the input channel.
  typedef struct packed {
    logic               start;
    logic               target;
    logic signed [11:0] yaw_err;
    logic signed [11:0] pitch_err;
    logic signed [15:0] yaw_pul;
    logic signed [15:0] pitch_pul;
    logic [15:0]        elapsed;
  } track_item_t;

  // Metrics reported for one sample.
  typedef struct packed {
    logic        settled;
    logic [15:0] yaw_settle;
    logic [15:0] pitch_settle;
    logic [15:0] yaw_cross;
    logic [15:0] pitch_cross;
    logic [15:0] yaw_step;
    logic [15:0] pitch_step;
    logic [11:0] yaw_perr;
    logic [11:0] pitch_perr;
    logic [15:0] valid_cnt;
    logic [15:0] lost_cnt;
  } metrics_t;

  // Tracked state of one axis; the error peak keeps 13 bits since 2048 is reachable.
  typedef struct packed {
    logic [1:0]         last_sign;
    logic [15:0]        crossings;
    logic signed [15:0] prev_pulses;
    logic [15:0]        step_peak;
    logic [15:0]        stable_run;
    logic [15:0]        settle;
    logic [12:0]        err_peak;
  } axis_state_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  logic               in_start_req;
  logic               in_target_valid;
  logic signed [11:0] in_yaw_error;
  logic signed [11:0] in_pitch_error;
  logic signed [15:0] in_yaw_pulses;
  logic signed [15:0] in_pitch_pulses;
  logic [15:0]        in_elapsed_ms;

  logic        out_valid;
  logic        out_stall;
  logic        out_settled;
  logic [15:0] out_yaw_settle_ms;
  logic [15:0] out_pitch_settle_ms;
  logic [15:0] out_yaw_crossings;
  logic [15:0] out_pitch_crossings;
  logic [15:0] out_yaw_peak_step;
  logic [15:0] out_pitch_peak_step;
  logic [11:0] out_yaw_peak_error;
  logic [11:0] out_pitch_peak_error;
  logic [15:0] out_valid_count;
  logic [15:0] out_lost_count;

  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  step_response_metrics_tracker DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_req         (in_start_req),
    .in_target_valid      (in_target_valid),
    .in_yaw_error         (in_yaw_error),
    .in_pitch_error       (in_pitch_error),
    .in_yaw_pulses        (in_yaw_pulses),
    .in_pitch_pulses      (in_pitch_pulses),
    .in_elapsed_ms        (in_elapsed_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_settled          (out_settled),
    .out_yaw_settle_ms    (out_yaw_settle_ms),
    .out_pitch_settle_ms  (out_pitch_settle_ms),
    .out_yaw_crossings    (out_yaw_crossings),
    .out_pitch_crossings  (out_pitch_crossings),
    .out_yaw_peak_step    (out_yaw_peak_step),
    .out_pitch_peak_step  (out_pitch_peak_step),
    .out_yaw_peak_error   (out_yaw_peak_error),
    .out_pitch_peak_error (out_pitch_peak_error),
    .out_valid_count      (out_valid_count),
    .out_lost_count       (out_lost_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the configuration, mirrored from every register write.
  logic [7:0]  deadband_q;
  logic [15:0] stable_len_q;
  logic        yaw_en_q;
  logic        pitch_en_q;

  // Predictor copy of the tracked metrics.
  axis_state_t yaw_st;
  axis_state_t pitch_st;
  logic        pulses_seen;
  logic [15:0] valid_tally;
  logic [15:0] lost_tally;

  metrics_t expected_metrics_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int results_checked;
  int items_sent;
  int configs_applied;

  function automatic logic [15:0] bump_sat(logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  // Advance one axis by one valid sample.
  function automatic axis_state_t track_axis(axis_state_t a, logic signed [11:0] err,
                                             logic signed [15:0] pul, logic [15:0] elapsed,
                                             logic seen);
    int e;
    int m;
    int db;
    int step;
    logic [1:0] sgn;
    e   = int'(err);
    m   = (e < 0) ? -e : e;
    db  = int'(deadband_q);
    sgn = SIGN_NONE;
    if (e > db) begin
      sgn = SIGN_POS;
    end else if (e < -db) begin
      sgn = SIGN_NEG;
    end
    // a sign flip only counts once the error leaves the band on the other side
    if (sgn != SIGN_NONE) begin
      if (a.last_sign != SIGN_NONE && a.last_sign != sgn) a.crossings = bump_sat(a.crossings);
      a.last_sign = sgn;
    end
    if (seen) begin
      step = int'(pul) - int'(a.prev_pulses);
      if (step < 0) step = -step;
      if (step > a.step_peak) a.step_peak = step[15:0];
    end
    a.prev_pulses = pul;
    if (m > a.err_peak) a.err_peak = m[12:0];
    if (m <= db) begin
      // a saturated run holds and never latches again
      if (a.stable_run != SAT16) begin
        a.stable_run = a.stable_run + 16'd1;
        if (a.stable_run == stable_len_q) a.settle = elapsed;
      end
    end else begin
      a.stable_run = '0;
      a.settle     = '0;
    end
    return a;
  endfunction

  // Update the predicted state with one accepted sample and return the metrics it yields.
  function automatic metrics_t predict_metrics(track_item_t s);
    int ym;
    int pm;
    metrics_t r;
    if (s.start) begin
      // clear everything, then seed the error peaks from this sample only
      ym          = (s.yaw_err < 0) ? -int'(s.yaw_err) : int'(s.yaw_err);
      pm          = (s.pitch_err < 0) ? -int'(s.pitch_err) : int'(s.pitch_err);
      yaw_st      = '0;
      pitch_st    = '0;
      pulses_seen = 1'b0;
      valid_tally = '0;
      lost_tally  = '0;
      yaw_st.err_peak   = ym[12:0];
      pitch_st.err_peak = pm[12:0];
    end else if (s.target) begin
      valid_tally = bump_sat(valid_tally);
      yaw_st      = track_axis(yaw_st, s.yaw_err, s.yaw_pul, s.elapsed, pulses_seen);
      pitch_st    = track_axis(pitch_st, s.pitch_err, s.pitch_pul, s.elapsed, pulses_seen);
      pulses_seen = 1'b1;
    end else begin
      // lost target breaks both runs but keeps the latched times
      lost_tally          = bump_sat(lost_tally);
      yaw_st.stable_run   = '0;
      pitch_st.stable_run = '0;
    end
    r.settled      = (!yaw_en_q || yaw_st.settle != 0) && (!pitch_en_q || pitch_st.settle != 0);
    r.yaw_settle   = yaw_st.settle;
    r.pitch_settle = pitch_st.settle;
    r.yaw_cross    = yaw_st.crossings;
    r.pitch_cross  = pitch_st.crossings;
    r.yaw_step     = yaw_st.step_peak;
    r.pitch_step   = pitch_st.step_peak;
    r.yaw_perr     = yaw_st.err_peak[11:0];
    r.pitch_perr   = pitch_st.err_peak[11:0];
    r.valid_cnt    = valid_tally;
    r.lost_cnt     = lost_tally;
    return r;
  endfunction

  function automatic string describe_diffs(metrics_t w, metrics_t g);
    string s;
    s = "";
    if (w.settled !== g.settled)
      s = {s, $sformatf(" settled %0d/%0d", w.settled, g.settled)};
    if (w.yaw_settle !== g.yaw_settle)
      s = {s, $sformatf(" yaw_settle %0d/%0d", w.yaw_settle, g.yaw_settle)};
    if (w.pitch_settle !== g.pitch_settle)
      s = {s, $sformatf(" pitch_settle %0d/%0d", w.pitch_settle, g.pitch_settle)};
    if (w.yaw_cross !== g.yaw_cross)
      s = {s, $sformatf(" yaw_cross %0d/%0d", w.yaw_cross, g.yaw_cross)};
    if (w.pitch_cross !== g.pitch_cross)
      s = {s, $sformatf(" pitch_cross %0d/%0d", w.pitch_cross, g.pitch_cross)};
    if (w.yaw_step !== g.yaw_step)
      s = {s, $sformatf(" yaw_step %0d/%0d", w.yaw_step, g.yaw_step)};
    if (w.pitch_step !== g.pitch_step)
      s = {s, $sformatf(" pitch_step %0d/%0d", w.pitch_step, g.pitch_step)};
    if (w.yaw_perr !== g.yaw_perr)
      s = {s, $sformatf(" yaw_peak_err %0d/%0d", w.yaw_perr, g.yaw_perr)};
    if (w.pitch_perr !== g.pitch_perr)
      s = {s, $sformatf(" pitch_peak_err %0d/%0d", w.pitch_perr, g.pitch_perr)};
    if (w.valid_cnt !== g.valid_cnt)
      s = {s, $sformatf(" valid_count %0d/%0d", w.valid_cnt, g.valid_cnt)};
    if (w.lost_cnt !== g.lost_cnt)
      s = {s, $sformatf(" lost_count %0d/%0d", w.lost_cnt, g.lost_cnt)};
    return s;
  endfunction

  // Receiver: stall at random with the current idle ratio.
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
  end

  // Result checker: compare each result transaction against the oldest prediction.
  always @(posedge clk) begin
    metrics_t got;
    metrics_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_settled, out_yaw_settle_ms, out_pitch_settle_ms, out_yaw_crossings,
             out_pitch_crossings, out_yaw_peak_step, out_pitch_peak_step,
             out_yaw_peak_error, out_pitch_peak_error, out_valid_count, out_lost_count};
      if (expected_metrics_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: result with nothing predicted", $realtime);
      end else begin
        want = expected_metrics_q.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result %0d mismatch (expected/actual):%s", $realtime,
                     results_checked, describe_diffs(want, got));
        end
      end
    end
  end

  function automatic track_item_t item_of(logic start, logic target, int ye, int pe,
                                          int yp, int pp, int el);
    track_item_t s;
    s.start     = start;
    s.target    = target;
    s.yaw_err   = 12'(ye);
    s.pitch_err = 12'(pe);
    s.yaw_pul   = 16'(yp);
    s.pitch_pul = 16'(pp);
    s.elapsed   = 16'(el);
    return s;
  endfunction

  function automatic int clamp12(int v);
    return (v > 2047) ? 2047 : (v < -2048) ? -2048 : v;
  endfunction

  // Send one sample: idle for a random gap, hold it until taken, then predict.
  task automatic send_item(input track_item_t s);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_start_req    <= s.start;
    in_target_valid <= s.target;
    in_yaw_error    <= s.yaw_err;
    in_pitch_error  <= s.pitch_err;
    in_yaw_pulses   <= s.yaw_pul;
    in_pitch_pulses <= s.pitch_pul;
    in_elapsed_ms   <= s.elapsed;
    do @(posedge clk); while (in_stall);
    expected_metrics_q.push_back(predict_metrics(s));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_metrics_q.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back, with the pipeline empty.
  task automatic apply_config(input int db, input int len, input bit yen, input bit pen);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [15:0]          val[4];
    wait_idle();
    idx = '{CFG_DEADBAND, CFG_STABLE_LEN, CFG_YAW_EN, CFG_PITCH_EN};
    val = '{db[15:0], len[15:0], {15'd0, yen}, {15'd0, pen}};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid    <= 1'b0;
    deadband_q   = db[7:0];
    stable_len_q = len[15:0];
    yaw_en_q     = yen;
    pitch_en_q   = pen;
    configs_applied++;
  endtask

  // Reset defaults: error extremes, pulse step extremes, crossings, the band
  // edge, a settle latched at time zero and an out-of-band sample that clears it.
  task automatic test_settle_and_extremes();
    send_item(item_of(1, 0, -2048, 2047, 0, 0, 0));
    send_item(item_of(0, 1, 10, -10, 32767, -32768, 3));
    send_item(item_of(0, 1, -10, 10, -32768, 32767, 4));
    send_item(item_of(0, 1, 4, -4, 0, 0, 5));
    send_item(item_of(0, 1, -4, 4, 1, -1, 6));
    send_item(item_of(0, 1, 0, 0, 2, -2, 7));
    send_item(item_of(0, 1, 3, -3, 3, -3, 8));
    send_item(item_of(0, 1, -1, 2, 4, -4, 0));
    send_item(item_of(0, 1, 5, 0, 5, -5, 65535));
  endtask

  // A lost sample breaks the runs but keeps latched times and other metrics.
  task automatic test_lost_target();
    send_item(item_of(1, 1, 7, -7, 1234, -1234, 999));
    for (int i = 0; i < 3; i++) send_item(item_of(0, 1, 1, -1, i, -i, 10 + i));
    send_item(item_of(0, 0, 500, -500, 30000, -30000, 15));
    for (int i = 0; i < 4; i++) send_item(item_of(0, 1, 0, 2, i, i, 20 + i));
    send_item(item_of(0, 1, -2, 0, 9, 9, 65535));
    send_item(item_of(0, 0, -2047, 2047, -1, -1, 1));
  endtask

  // Register corners: widest band with run length one, zero band with run
  // length zero and both axes off, and one axis off.
  task automatic test_config_corners();
    apply_config(255, 1, 1, 1);
    send_item(item_of(1, 0, 0, 0, 0, 0, 0));
    send_item(item_of(0, 1, 255, -255, 100, -100, 42));
    send_item(item_of(0, 1, 256, -256, 100, -100, 43));
    apply_config(0, 0, 0, 0);
    send_item(item_of(0, 1, 0, 0, 7, 7, 50));
    send_item(item_of(0, 1, 1, -1, 7, 7, 51));
    apply_config(0, 2, 1, 0);
    send_item(item_of(0, 1, 0, -5, 0, 0, 7));
    send_item(item_of(0, 1, 0, 5, 0, 0, 8));
  endtask

  task automatic pick_config();
    int r;
    int db;
    int len;
    r   = $urandom_range(0, 9);
    db  = (r == 0) ? 255 : (r == 1) ? 0 : $urandom_range(1, 40);
    r   = $urandom_range(0, 11);
    len = (r == 0) ? 0 : (r == 1) ? 65535 : (r == 2) ? 1 : $urandom_range(2, 8);
    apply_config(db, len, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
  endtask

  // Mostly step responses: a start, then an oscillation that decays into the
  // band with drifting pulses and the odd lost sample; the rest is raw noise.
  task automatic test_random_tracking(input int n_items);
    int sent;
    int len;
    int ya, pa, ys, ps, yp, pp, el;
    int ye, pe;
    logic [95:0] raw;
    track_item_t s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        raw = {$urandom, $urandom, $urandom};
        s   = raw[$bits(track_item_t)-1:0];
        send_item(s);
        sent++;
      end else begin
        len = $urandom_range(4, 30);
        ya  = $urandom_range(0, 2047);
        pa  = $urandom_range(0, 2047);
        ys  = $urandom_range(0, 1) ? 1 : -1;
        ps  = $urandom_range(0, 1) ? 1 : -1;
        yp  = int'($urandom_range(0, 65535)) - 32768;
        pp  = int'($urandom_range(0, 65535)) - 32768;
        el  = $urandom_range(0, 100);
        send_item(item_of(1, 1'($urandom_range(0, 1)), ys * ya, ps * pa, yp, pp, el));
        sent++;
        for (int i = 0; i < len && sent < n_items; i++) begin
          ya = ya * int'($urandom_range(30, 95)) / 100;
          pa = pa * int'($urandom_range(30, 95)) / 100;
          if ($urandom_range(0, 9) < 7) ys = -ys;
          if ($urandom_range(0, 9) < 7) ps = -ps;
          ye = clamp12(ys * ya + int'($urandom_range(0, 4)) - 2);
          pe = clamp12(ps * pa + int'($urandom_range(0, 4)) - 2);
          // land on either side of the band edge now and then
          if ($urandom_range(0, 9) == 0)
            ye = clamp12(ys * (int'(deadband_q) + int'($urandom_range(0, 1))));
          if ($urandom_range(0, 9) == 0)
            pe = clamp12(ps * (int'(deadband_q) + int'($urandom_range(0, 1))));
          yp += int'($urandom_range(0, 3000)) - 1500;
          pp += int'($urandom_range(0, 3000)) - 1500;
          if ($urandom_range(0, 19) == 0) yp = $urandom;
          if ($urandom_range(0, 19) == 0) pp = $urandom;
          el = (el + int'($urandom_range(1, 60))) % 65536;
          send_item(item_of(0, $urandom_range(0, 99) >= 8, ye, pe, yp, pp, el));
          sent++;
        end
      end
    end
  endtask

  task automatic run_random_phase(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < 3; k++) begin
      pick_config();
      test_random_tracking(115);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_start_req    <= 1'b0;
    in_target_valid <= 1'b0;
    in_yaw_error    <= '0;
    in_pitch_error  <= '0;
    in_yaw_pulses   <= '0;
    in_pitch_pulses <= '0;
    in_elapsed_ms   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_DEADBAND;
    cfg_data        <= '0;
    // reset values of the registers and the metrics
    deadband_q      = 8'd4;
    stable_len_q    = 16'd5;
    yaw_en_q        = 1'b1;
    pitch_en_q      = 1'b1;
    yaw_st          = '0;
    pitch_st        = '0;
    pulses_seen     = 1'b0;
    valid_tally     = '0;
    lost_tally      = '0;
    send_idle_pct   = 35;
    recv_idle_pct   = 55;
    mismatch_count  = 0;
    results_checked = 0;
    items_sent      = 0;
    configs_applied = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_settle_and_extremes();
    test_lost_target();
    test_config_corners();
    run_random_phase(35, 55);
    run_random_phase(55, 35);
    run_random_phase(0, 0);

    // let the last results out, then allow for the input and result registers
    wait_idle();
    repeat (4) @(posedge clk);
    $display("summary: %0d samples sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("summary: directed corners, lost targets and %0d register settings",
             configs_applied);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #20000000;
    $display("tb: errors");
    $finish;
  end

endmodule
